// ----- hw/rtl/rci_pkg.sv -----
// Package for the ray / truncated cone intersection pipeline.
// Holds fixed-point constants, stage counts, shared types and arithmetic helpers.
// No dependencies.
package rci_pkg;

  // Q8.FRAC_BITS fixed point
  localparam int FRAC_BITS = 24;
  localparam int PW        = 64 - FRAC_BITS;     // width of a scaled 32x32 product
  localparam int SW        = 66;                 // wide signed sum width
  localparam int CFG_W     = FRAC_BITS + 1;      // register width
  localparam int NSLOT     = 4;                  // side +, side -, cap, base

  // Register map
  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-1:0] ADDR_BASE_LEVEL = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_NEAR_ZERO  = 3'd4;
  localparam logic [CFG_W-1:0]  BASE_LEVEL_RST  = CFG_W'(1) << (FRAC_BITS - 1);
  localparam logic [CFG_W-1:0]  NEAR_ZERO_RST   = CFG_W'(16);

  // 1.0 in fixed point, with headroom
  localparam logic signed [33:0] ONE_Q = 34'sd1 <<< FRAC_BITS;

  // Square root unit: radicand is a 31-bit value shifted up by FRAC_BITS
  localparam int SQ_W   = ((31 + FRAC_BITS + 1) / 2) * 2;
  localparam int SQ_RW  = SQ_W / 2;
  localparam int SQ_SPS = 4;
  localparam int SQ_STG = (SQ_RW + SQ_SPS - 1) / SQ_SPS;

  // Divider: |numerator| <= 2^33, |denominator| <= 2^32, 32 quotient bits
  localparam int DN_W   = 35;
  localparam int DD_W   = 33;
  localparam int DV_QB  = 32;
  localparam int DV_RW  = 34;
  localparam int DV_NW  = DN_W - 1 + FRAC_BITS;
  localparam int DV_SPS = 4;
  localparam int DV_STG = (DV_QB + DV_SPS - 1) / DV_SPS;
  localparam int DV_LAT = DV_STG + 2;

  // Sideband delay from quadratic stage to hit test
  localparam int SB_D = SQ_STG + DV_LAT;

  typedef logic signed [31:0] q_t;

  localparam q_t Q_MAX = 32'sh7FFFFFFF;
  localparam q_t Q_MIN = 32'sh80000000;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_SIDE = 2'd1,
    KIND_CAP  = 2'd2,
    KIND_BASE = 2'd3
  } kind_t;

  // Per-ray data that travels alongside the arithmetic units
  typedef struct packed {
    q_t   ox;
    q_t   oy;
    q_t   oz;
    q_t   dx;
    q_t   dy;
    q_t   dz;
    q_t   a;
    q_t   b;
    q_t   c;
    logic lin;    // linear root in slot 0
    logic quad;   // both quadratic roots valid
    logic dzok;   // disks are tested
  } ray_sb_t;

  // Hit test result handed to the output serializer
  typedef struct packed {
    logic                        vld;
    logic [NSLOT-1:0]            mask;
    logic [NSLOT-1:0][31:0]      tval;
  } hit_res_t;

  // Clamp to the 32-bit signed range
  function automatic q_t sat32(input logic signed [SW-1:0] x);
    if (x > SW'(Q_MAX)) return Q_MAX;
    if (x < SW'(Q_MIN)) return Q_MIN;
    return x[31:0];
  endfunction

  // floor(p*q / 2^FRAC_BITS)
  function automatic logic signed [PW-1:0] mulq(input q_t p, input q_t q);
    logic signed [63:0] pr;
    pr = 64'(p) * 64'(q);
    return pr[63:FRAC_BITS];
  endfunction

  // Magnitude of a 32-bit signed value
  function automatic logic [32:0] abs33(input q_t x);
    logic signed [32:0] w;
    w = 33'(x);
    return x[31] ? 33'(-w) : 33'(w);
  endfunction

endpackage

// ----- hw/rtl/rci_quad.sv -----
// Coefficient stages: products, a/b/c, discriminant and root-finding flags.
// Four register stages. Depends on rci_pkg.
module rci_quad (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_vld,
  input  rci_pkg::q_t                 ox,
  input  rci_pkg::q_t                 oy,
  input  rci_pkg::q_t                 oz,
  input  rci_pkg::q_t                 dx,
  input  rci_pkg::q_t                 dy,
  input  rci_pkg::q_t                 dz,
  input  logic [rci_pkg::CFG_W-1:0]   eps,
  output logic                        out_vld,
  output rci_pkg::ray_sb_t            sb,
  output logic [rci_pkg::SQ_W-1:0]    rad
);
  import rci_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r;
  ray_sb_t sb1_r, sb2_r, sb3_r, sb4_r;
  logic signed [PW-1:0] ddx_r, ddy_r, ddz_r, odx_r, ody_r, odz_r, oox_r, ooy_r, ooz_r;
  logic signed [PW-1:0] bb_r, ac_r;
  logic deg_r, bok_r;
  logic [SQ_W-1:0] rad_r;

  ray_sb_t sb1_nxt, sb2_nxt, sb4_nxt;
  logic signed [SW-1:0] delta;
  q_t dsat;

  // stage 1: the nine products
  always_comb begin
    sb1_nxt      = '0;
    sb1_nxt.ox   = ox;
    sb1_nxt.oy   = oy;
    sb1_nxt.oz   = oz;
    sb1_nxt.dx   = dx;
    sb1_nxt.dy   = dy;
    sb1_nxt.dz   = dz;
    sb1_nxt.dzok = abs33(dz) > 33'(eps);
  end

  // stage 2: saturated coefficients
  always_comb begin
    sb2_nxt   = sb1_r;
    sb2_nxt.a = sat32(SW'(ddx_r) + SW'(ddy_r) - SW'(ddz_r));
    sb2_nxt.b = sat32(SW'(odx_r) + SW'(ody_r) - SW'(odz_r));
    sb2_nxt.c = sat32(SW'(oox_r) + SW'(ooy_r) - SW'(ooz_r));
  end

  // stage 4: discriminant and root selection
  always_comb begin
    delta        = SW'(bb_r) - SW'(ac_r);
    dsat         = sat32(delta);
    sb4_nxt      = sb3_r;
    sb4_nxt.quad = !deg_r && !delta[SW-1];
    sb4_nxt.lin  = deg_r && bok_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb1_r <= sb1_nxt;
      ddx_r <= mulq(dx, dx);
      ddy_r <= mulq(dy, dy);
      ddz_r <= mulq(dz, dz);
      odx_r <= mulq(ox, dx);
      ody_r <= mulq(oy, dy);
      odz_r <= mulq(oz, dz);
      oox_r <= mulq(ox, ox);
      ooy_r <= mulq(oy, oy);
      ooz_r <= mulq(oz, oz);

      sb2_r <= sb2_nxt;

      sb3_r <= sb2_r;
      bb_r  <= mulq(sb2_r.b, sb2_r.b);
      ac_r  <= mulq(sb2_r.a, sb2_r.c);
      deg_r <= (abs33(sb2_r.a) < 33'(eps)) || (sb2_r.a == '0);
      bok_r <= abs33(sb2_r.b) > 33'(eps);

      sb4_r <= sb4_nxt;
      rad_r <= SQ_W'(dsat[30:0]) << FRAC_BITS;
    end
  end

  assign out_vld = v4_r;
  assign sb      = sb4_r;
  assign rad     = rad_r;

endmodule

// ----- hw/rtl/rci_sqrt.sv -----
// Pipelined integer square root, a few result bits per stage.
// Depends on rci_pkg.
module rci_sqrt (
  input  logic                        clk,
  input  logic                        adv,
  input  logic [rci_pkg::SQ_W-1:0]    rad,
  output logic [rci_pkg::SQ_RW-1:0]   root
);
  import rci_pkg::*;

  logic [SQ_RW+1:0] rem_r  [SQ_STG];
  logic [SQ_RW-1:0] root_r [SQ_STG];
  logic [SQ_W-1:0]  rad_r  [SQ_STG];

  for (genvar s = 0; s < SQ_STG; s++) begin : g_stg
    logic [SQ_RW+1:0] rem_i, rem_o;
    logic [SQ_RW-1:0] root_i, root_o;
    logic [SQ_W-1:0]  rad_i, rad_o;

    if (s == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = rad;
    end else begin : g_next
      assign rem_i  = rem_r[s-1];
      assign root_i = root_r[s-1];
      assign rad_i  = rad_r[s-1];
    end

    // restoring digit recurrence, two radicand bits per step
    always_comb begin
      logic [SQ_RW+1:0] rx;
      logic [SQ_RW+1:0] tr;
      rem_o  = rem_i;
      root_o = root_i;
      rad_o  = rad_i;
      for (int k = 0; k < SQ_SPS; k++) begin
        if (s * SQ_SPS + k < SQ_RW) begin
          rx    = {rem_o[SQ_RW-1:0], rad_o[SQ_W-1 -: 2]};
          tr    = {root_o, 2'b01};
          rad_o = rad_o << 2;
          if (rx >= tr) begin
            rem_o  = rx - tr;
            root_o = {root_o[SQ_RW-2:0], 1'b1};
          end else begin
            rem_o  = rx;
            root_o = {root_o[SQ_RW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s]  <= rem_o;
        root_r[s] <= root_o;
        rad_r[s]  <= rad_o;
      end
    end
  end

  assign root = root_r[SQ_STG-1];

endmodule

// ----- hw/rtl/rci_div.sv -----
// Pipelined fixed-point divider: trunc(num * 2^FRAC_BITS / den), saturated to 32 bits.
// Setup stage, DV_STG restoring stages, sign stage. Depends on rci_pkg.
module rci_div (
  input  logic                              clk,
  input  logic                              adv,
  input  logic signed [rci_pkg::DN_W-1:0]   num,
  input  logic signed [rci_pkg::DD_W-1:0]   den,
  output rci_pkg::q_t                       quo
);
  import rci_pkg::*;

  logic [DV_RW-1:0] rem_r [DV_STG+1];
  logic [DV_QB-1:0] lo_r  [DV_STG+1];
  logic [DV_QB-1:0] q_r   [DV_STG+1];
  logic [DD_W-1:0]  dn_r  [DV_STG+1];
  logic             ovf_r [DV_STG+1];
  logic             neg_r [DV_STG+1];
  q_t               quo_r;

  logic [DN_W-2:0]  an;
  logic [DD_W-1:0]  dn;
  logic [DV_NW-1:0] nw;
  logic [DV_NW-DV_QB-1:0] hi;
  q_t               quo_nxt;

  // setup: magnitudes and overflow test on the upper part
  always_comb begin
    an = num[DN_W-1] ? (DN_W-1)'(-num) : (DN_W-1)'(num);
    dn = den[DD_W-1] ? DD_W'(-den) : DD_W'(den);
    nw = {an, {FRAC_BITS{1'b0}}};
    hi = nw[DV_NW-1:DV_QB];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= DV_RW'(hi);
      lo_r[0]  <= nw[DV_QB-1:0];
      q_r[0]   <= '0;
      dn_r[0]  <= dn;
      ovf_r[0] <= DV_RW'(hi) >= DV_RW'(dn);
      neg_r[0] <= num[DN_W-1] ^ den[DD_W-1];
    end
  end

  for (genvar s = 1; s <= DV_STG; s++) begin : g_stg
    logic [DV_RW-1:0] rem_o;
    logic [DV_QB-1:0] lo_o, q_o;

    always_comb begin
      logic [DV_RW-1:0] rx;
      rem_o = rem_r[s-1];
      lo_o  = lo_r[s-1];
      q_o   = q_r[s-1];
      for (int k = 0; k < DV_SPS; k++) begin
        if ((s - 1) * DV_SPS + k < DV_QB) begin
          rx   = {rem_o[DV_RW-2:0], lo_o[DV_QB-1]};
          lo_o = lo_o << 1;
          if (rx >= DV_RW'(dn_r[s-1])) begin
            rem_o = rx - DV_RW'(dn_r[s-1]);
            q_o   = {q_o[DV_QB-2:0], 1'b1};
          end else begin
            rem_o = rx;
            q_o   = {q_o[DV_QB-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s] <= rem_o;
        lo_r[s]  <= lo_o;
        q_r[s]   <= q_o;
        dn_r[s]  <= dn_r[s-1];
        ovf_r[s] <= ovf_r[s-1];
        neg_r[s] <= neg_r[s-1];
      end
    end
  end

  // sign and saturation
  always_comb begin
    if (ovf_r[DV_STG]) begin
      quo_nxt = neg_r[DV_STG] ? Q_MIN : Q_MAX;
    end else if (neg_r[DV_STG]) begin
      quo_nxt = (q_r[DV_STG] > 32'h80000000) ? Q_MIN : q_t'(-q_r[DV_STG]);
    end else begin
      quo_nxt = q_r[DV_STG][31] ? Q_MAX : q_t'(q_r[DV_STG]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) quo_r <= quo_nxt;
  end

  assign quo = quo_r;

endmodule

// ----- hw/rtl/rci_hit.sv -----
// Hit qualification: side z range check and cap/base disk containment.
// Four register stages. Depends on rci_pkg.
module rci_hit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_vld,
  input  rci_pkg::q_t                 t [rci_pkg::NSLOT],
  input  rci_pkg::ray_sb_t            sb,
  input  logic [rci_pkg::CFG_W-1:0]   bl,
  output rci_pkg::hit_res_t           res
);
  import rci_pkg::*;

  localparam int BL2_W = 2 * CFG_W - FRAC_BITS;

  logic v1_r, v2_r, v3_r, v4_r;
  q_t t1_r [NSLOT];
  q_t t2_r [NSLOT];
  q_t t3_r [NSLOT];
  ray_sb_t sb1_r;
  logic signed [PW-1:0] mz0_r, mz1_r, mcx_r, mcy_r, mbx_r, mby_r;
  logic [1:0] sok2_r, sok3_r;
  logic dzok2_r, dzok3_r;
  q_t pcx_r, pcy_r, pbx_r, pby_r;
  logic signed [PW-1:0] scx_r, scy_r, sbx_r, sby_r;
  logic [BL2_W-1:0] bl2_r;
  logic [NSLOT-1:0] mask_r;
  logic [NSLOT-1:0][31:0] dist_r;

  logic signed [SW-1:0] blw, onew, z0, z1;
  logic [1:0] sok_nxt;
  logic [2*CFG_W-1:0] blsq;
  logic capin, basein;

  // stage 2: side z window
  always_comb begin
    blw        = SW'(signed'({1'b0, bl}));
    onew       = SW'(ONE_Q);
    z0         = SW'(sb1_r.oz) + SW'(mz0_r);
    z1         = SW'(sb1_r.oz) + SW'(mz1_r);
    sok_nxt[0] = (sb1_r.lin || sb1_r.quad) && (z0 >= blw) && (z0 <= onew);
    sok_nxt[1] = sb1_r.quad && (z1 >= blw) && (z1 <= onew);
  end

  // stage 4: disk containment
  always_comb begin
    blsq   = (2*CFG_W)'(bl) * (2*CFG_W)'(bl);
    capin  = (SW'(scx_r) + SW'(scy_r)) <= SW'(ONE_Q);
    basein = (SW'(sbx_r) + SW'(sby_r)) <= SW'(signed'({1'b0, bl2_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: products with the direction
      t1_r  <= t;
      sb1_r <= sb;
      mz0_r <= mulq(t[0], sb.dz);
      mz1_r <= mulq(t[1], sb.dz);
      mcx_r <= mulq(t[2], sb.dx);
      mcy_r <= mulq(t[2], sb.dy);
      mbx_r <= mulq(t[3], sb.dx);
      mby_r <= mulq(t[3], sb.dy);

      // stage 2: disk points
      t2_r    <= t1_r;
      sok2_r  <= sok_nxt;
      dzok2_r <= sb1_r.dzok;
      pcx_r   <= sat32(SW'(sb1_r.ox) + SW'(mcx_r));
      pcy_r   <= sat32(SW'(sb1_r.oy) + SW'(mcy_r));
      pbx_r   <= sat32(SW'(sb1_r.ox) + SW'(mbx_r));
      pby_r   <= sat32(SW'(sb1_r.oy) + SW'(mby_r));

      // stage 3: squared radii
      t3_r    <= t2_r;
      sok3_r  <= sok2_r;
      dzok3_r <= dzok2_r;
      scx_r   <= mulq(pcx_r, pcx_r);
      scy_r   <= mulq(pcy_r, pcy_r);
      sbx_r   <= mulq(pbx_r, pbx_r);
      sby_r   <= mulq(pby_r, pby_r);
      bl2_r   <= blsq[2*CFG_W-1:FRAC_BITS];

      // stage 4: slot mask
      mask_r <= {dzok3_r && basein, dzok3_r && capin, sok3_r};
      for (int i = 0; i < NSLOT; i++) dist_r[i] <= t3_r[i];
    end
  end

  assign res.vld  = v4_r;
  assign res.mask = mask_r;
  assign res.tval = dist_r;

endmodule

// ----- hw/rtl/rci_emit.sv -----
// Output serializer: emits the hits of one ray in slot order, or one none beat.
// Also produces the pipeline advance. Depends on rci_pkg.
module rci_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  rci_pkg::hit_res_t  res,
  output logic               adv,
  output logic               out_valid,
  input  logic               out_stall,
  output rci_pkg::q_t        out_hit_distance,
  output rci_pkg::kind_t     out_hit_kind,
  output logic               out_last_hit
);
  import rci_pkg::*;

  logic                   busy_r;
  logic [NSLOT-1:0]       mask_r;
  logic [NSLOT-1:0][31:0] dist_r;

  logic [1:0]       slot;
  logic [NSLOT-1:0] rest;
  logic             none, last, take;

  // lowest pending slot
  always_comb begin
    if (mask_r[0])      slot = 2'd0;
    else if (mask_r[1]) slot = 2'd1;
    else if (mask_r[2]) slot = 2'd2;
    else                slot = 2'd3;
    rest = mask_r & ~(NSLOT'(1) << slot);
    none = (mask_r == '0);
    last = none || (rest == '0);
    take = busy_r && !out_stall;
    adv  = !busy_r || (take && last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (adv) begin
      busy_r <= res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mask_r <= res.mask;
      dist_r <= res.tval;
    end else if (take) begin
      mask_r <= rest;
    end
  end

  // beat payload
  always_comb begin
    out_valid        = busy_r;
    out_last_hit     = last;
    out_hit_distance = none ? '0 : q_t'(dist_r[slot]);
    if (none) begin
      out_hit_kind = KIND_NONE;
    end else begin
      case (slot)
        2'd0, 2'd1: out_hit_kind = KIND_SIDE;
        2'd2:       out_hit_kind = KIND_CAP;
        default:    out_hit_kind = KIND_BASE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/ray_cone_intersection.sv -----
// Top level of the ray / truncated cone intersection pipeline.
// Instantiates rci_quad, rci_sqrt, rci_div, rci_hit and rci_emit; uses rci_pkg.
//
// Takes one ray per beat, already in canonical cone space, and returns its hits
// in slot order (side root +, side root -, cap disk, base disk), or a single
// none beat; last_hit marks the final beat of each ray. The pipeline takes a
// new ray every cycle; a ray with k hits occupies the output for k beats, and
// the whole pipeline holds while the output serializer is still sending or
// out_stall holds its beat. A ray passes 4 coefficient stages, 7 square root
// stages, 10 divider stages, 4 hit test stages and the output register.
// base_level and near_zero sit at APB byte addresses 0 and 4; the user must
// write them only while no ray is in flight, as the block does not enforce it.
module ray_cone_intersection (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rci_pkg::q_t                   in_origin_x,
  input  rci_pkg::q_t                   in_origin_y,
  input  rci_pkg::q_t                   in_origin_z,
  input  rci_pkg::q_t                   in_dir_x,
  input  rci_pkg::q_t                   in_dir_y,
  input  rci_pkg::q_t                   in_dir_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rci_pkg::q_t                   out_hit_distance,
  output rci_pkg::kind_t                out_hit_kind,
  output logic                          out_last_hit,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rci_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import rci_pkg::*;

  logic [CFG_W-1:0] base_level_r, near_zero_r;
  logic adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_level_r <= BASE_LEVEL_RST;
      near_zero_r  <= NEAR_ZERO_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr == ADDR_BASE_LEVEL) base_level_r <= pwdata[CFG_W-1:0];
      if (paddr == ADDR_NEAR_ZERO)  near_zero_r  <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    pready = 1'b1;
    if (paddr == ADDR_BASE_LEVEL)     prdata = 32'(base_level_r);
    else if (paddr == ADDR_NEAR_ZERO) prdata = 32'(near_zero_r);
    else                              prdata = '0;
  end

  assign in_stall = !adv;

  // coefficients and discriminant
  logic             q_vld;
  ray_sb_t          q_sb;
  logic [SQ_W-1:0]  q_rad;

  rci_quad u_quad (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_vld (in_valid),
    .ox     (in_origin_x),
    .oy     (in_origin_y),
    .oz     (in_origin_z),
    .dx     (in_dir_x),
    .dy     (in_dir_y),
    .dz     (in_dir_z),
    .eps    (near_zero_r),
    .out_vld(q_vld),
    .sb     (q_sb),
    .rad    (q_rad)
  );

  logic [SQ_RW-1:0] root;

  rci_sqrt u_sqrt (
    .clk (clk),
    .adv (adv),
    .rad (q_rad),
    .root(root)
  );

  // sideband delay line alongside square root and dividers
  ray_sb_t         sb_r [SB_D];
  logic [SB_D-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[SB_D-2:0], q_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r[0] <= q_sb;
      for (int i = 1; i < SB_D; i++) sb_r[i] <= sb_r[i-1];
    end
  end

  // divider operands
  ray_sb_t                 sbs;
  logic signed [DN_W-1:0]  nb, sq, num [NSLOT];
  logic signed [DD_W-1:0]  den [NSLOT];

  always_comb begin
    sbs    = sb_r[SQ_STG-1];
    nb     = -DN_W'(sbs.b);
    sq     = DN_W'(signed'({1'b0, root}));
    num[0] = sbs.lin ? -DN_W'(sbs.c) : nb + sq;
    den[0] = sbs.lin ? (DD_W'(sbs.b) <<< 1) : DD_W'(sbs.a);
    num[1] = nb - sq;
    den[1] = DD_W'(sbs.a);
    num[2] = DN_W'(ONE_Q) - DN_W'(sbs.oz);
    den[2] = DD_W'(sbs.dz);
    num[3] = DN_W'(signed'({1'b0, base_level_r})) - DN_W'(sbs.oz);
    den[3] = DD_W'(sbs.dz);
  end

  q_t tq [NSLOT];

  for (genvar i = 0; i < NSLOT; i++) begin : g_div
    rci_div u_div (
      .clk(clk),
      .adv(adv),
      .num(num[i]),
      .den(den[i]),
      .quo(tq[i])
    );
  end

  hit_res_t hres;

  rci_hit u_hit (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .in_vld(vld_r[SB_D-1]),
    .t     (tq),
    .sb    (sb_r[SB_D-1]),
    .bl    (base_level_r),
    .res   (hres)
  );

  rci_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .res             (hres),
    .adv             (adv),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit_distance(out_hit_distance),
    .out_hit_kind    (out_hit_kind),
    .out_last_hit    (out_last_hit)
  );

endmodule

// ----- sim/tb_ray_cone_intersection.sv -----
// Self-checking testbench for ray_cone_intersection: directed rays, then random rays
// scored against a fixed-point predictor of the cone and disk tests.
// Depends on rci_pkg and the ray_cone_intersection RTL only.
module tb_ray_cone_intersection;
  timeunit 1ns;
  timeprecision 1ps;
  import rci_pkg::*;

  localparam int  FB       = rci_pkg::FRAC_BITS;
  localparam int  SETTLE   = 40;   // pipeline latency plus margin
  localparam int  N_ROWS   = 12;
  localparam int  N_PHASES = 5;
  localparam int  N_RAND   = 72;   // random rays per setting
  localparam q_t  ONE      = 32'sh0100_0000;

  typedef struct {
    q_t    tval;
    kind_t kind;
    logic  last;
  } hit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  q_t   in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  q_t   in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  q_t   out_hit_distance;
  kind_t out_hit_kind;
  logic out_last_hit;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ray_cone_intersection i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_origin_x(in_origin_x), .in_origin_y(in_origin_y), .in_origin_z(in_origin_z),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_hit_distance(out_hit_distance), .out_hit_kind(out_hit_kind),
    .out_last_hit(out_last_hit),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // Shadow of the registers and the queue of expected hit beats
  logic [CFG_W-1:0] cur_base_level = BASE_LEVEL_RST;
  logic [CFG_W-1:0] cur_near_zero  = NEAR_ZERO_RST;
  hit_t pending_hits[$];
  int   errors = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // ---------------- fixed-point predictor ----------------
  function automatic longint fx_sat(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint fx_mul(input longint p, input longint q);
    longint r;
    r = p * q;
    return r >>> FB;   // floor
  endfunction

  function automatic longint fx_div(input longint n, input longint d);
    return (n * (64'sd1 <<< FB)) / d;   // truncates toward zero
  endfunction

  function automatic longint unsigned fx_isqrt(input longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic bit in_disk(input longint ox, input longint oy, input longint dx,
                                 input longint dy, input longint d, input longint r);
    longint px, py;
    px = fx_sat(ox + fx_mul(d, dx));
    py = fx_sat(oy + fx_mul(d, dy));
    return fx_mul(px, px) + fx_mul(py, py) <= fx_mul(r, r);
  endfunction

  // Works out the hit beats of one ray and queues them
  function automatic void predict_ray(input q_t qox, input q_t qoy, input q_t qoz,
                                      input q_t qdx, input q_t qdy, input q_t qdz);
    longint ox, oy, oz, dx, dy, dz, a, b, c, dl, s, eps, bl, one, d, z;
    longint tv[4];
    kind_t  kd[4];
    int     n, last_slot;
    hit_t   h;
    ox = qox; oy = qoy; oz = qoz; dx = qdx; dy = qdy; dz = qdz;
    eps = longint'(cur_near_zero);
    bl  = longint'(cur_base_level);
    one = 64'sd1 <<< FB;
    for (int i = 0; i < 4; i++) begin
      tv[i] = 0;
      kd[i] = KIND_NONE;
    end
    a = fx_sat(fx_mul(dx, dx) + fx_mul(dy, dy) - fx_mul(dz, dz));
    b = fx_sat(fx_mul(ox, dx) + fx_mul(oy, dy) - fx_mul(oz, dz));
    c = fx_sat(fx_mul(ox, ox) + fx_mul(oy, oy) - fx_mul(oz, oz));
    // side surface: linear fallback or half-b quadratic
    if ((a < 0 ? -a : a) < eps || a == 0) begin
      if ((b < 0 ? -b : b) > eps) begin
        tv[0] = fx_sat(fx_div(-c, 2 * b));
        kd[0] = KIND_SIDE;
      end
    end else begin
      dl = fx_mul(b, b) - fx_mul(a, c);
      if (dl >= 0) begin
        s = longint'(fx_isqrt(longint'(fx_sat(dl)) << FB));
        tv[0] = fx_sat(fx_div(-b + s, a));
        tv[1] = fx_sat(fx_div(-b - s, a));
        kd[0] = KIND_SIDE;
        kd[1] = KIND_SIDE;
      end
    end
    // side hits must lie between base plane and cap
    for (int i = 0; i < 2; i++) begin
      if (kd[i] == KIND_SIDE) begin
        z = oz + fx_mul(tv[i], dz);
        if (!(z >= bl && z <= one)) kd[i] = KIND_NONE;
      end
    end
    // end disks, skipped for a flat direction
    if ((dz < 0 ? -dz : dz) > eps) begin
      d = fx_sat(fx_div(one - oz, dz));
      if (in_disk(ox, oy, dx, dy, d, one)) begin
        tv[2] = d;
        kd[2] = KIND_CAP;
      end
      d = fx_sat(fx_div(bl - oz, dz));
      if (in_disk(ox, oy, dx, dy, d, bl)) begin
        tv[3] = d;
        kd[3] = KIND_BASE;
      end
    end
    n = 0;
    last_slot = -1;
    for (int i = 0; i < 4; i++) if (kd[i] != KIND_NONE) last_slot = i;
    if (last_slot < 0) begin
      h.tval = '0;
      h.kind = KIND_NONE;
      h.last = 1'b1;
      pending_hits.push_back(h);
    end else begin
      for (int i = 0; i < 4; i++) begin
        if (kd[i] != KIND_NONE) begin
          h.tval = q_t'(tv[i]);
          h.kind = kd[i];
          h.last = (i == last_slot);
          pending_hits.push_back(h);
        end
      end
    end
  endfunction

  // ---------------- result side ----------------
  logic  smp_valid, smp_stall, smp_last;
  q_t    smp_dist;
  kind_t smp_kind;

  // outputs are stable at the falling edge; score them at the next rising edge
  always @(negedge clk) begin
    smp_valid = (out_valid === 1'b1);
    smp_stall = out_stall;
    smp_dist  = out_hit_distance;
    smp_kind  = out_hit_kind;
    smp_last  = out_last_hit;
  end

  always @(posedge clk) begin
    hit_t want;
    if (rst_n && smp_valid && !smp_stall) begin
      if (pending_hits.size() == 0) begin
        report_mismatch("unexpected hit beat", smp_kind, KIND_NONE);
      end else begin
        want = pending_hits.pop_front();
        if (smp_dist !== want.tval) report_mismatch("hit_distance", smp_dist, want.tval);
        if (smp_kind !== want.kind) report_mismatch("hit_kind", smp_kind, want.kind);
        if (smp_last !== want.last) report_mismatch("last_hit", smp_last, want.last);
      end
    end
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_idle_pct);
  end

  // ---------------- input side ----------------
  task automatic send_ray(input q_t ox, input q_t oy, input q_t oz,
                          input q_t dx, input q_t dy, input q_t dz);
    logic stl;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_origin_x <= ox; in_origin_y <= oy; in_origin_z <= oz;
    in_dir_x <= dx; in_dir_y <= dy; in_dir_z <= dz;
    do begin
      @(negedge clk);
      stl = in_stall;
      @(posedge clk);
    end while (stl);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_check(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] want);
    logic [31:0] got;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    got = prdata;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
    if (got[CFG_W-1:0] !== want) report_mismatch("register readback", got, want);
  endtask

  task automatic set_regs(input logic [CFG_W-1:0] bl, input logic [CFG_W-1:0] nz);
    apb_write(ADDR_BASE_LEVEL, 32'(bl));
    apb_write(ADDR_NEAR_ZERO, 32'(nz));
    cur_base_level = bl;
    cur_near_zero  = nz;
    apb_check(ADDR_BASE_LEVEL, bl);
    apb_check(ADDR_NEAR_ZERO, nz);
  endtask

  function automatic q_t rand_span(input int unsigned half);
    return q_t'($urandom_range(0, 2 * half)) - q_t'(half);
  endfunction

  function automatic q_t pick_extreme();
    case ($urandom_range(0, 5))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return ONE;
      3: return -ONE;
      4: return q_t'($urandom_range(0, 40)) - 20;
      default: return '0;
    endcase
  endfunction

  // Mostly well-formed rays near the cone, some degenerate, some noise
  task automatic send_random_ray();
    q_t f[6];
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      for (int k = 0; k < 3; k++) f[k] = rand_span(3 << FB);
      for (int k = 3; k < 6; k++) f[k] = rand_span(2 << FB);
      case ($urandom_range(0, 6))
        0: f[5] = rand_span(32);                          // almost flat
        1: begin                                          // a close to zero
          f[4] = '0;
          f[3] = f[5] + rand_span(8);
        end
        default: ;
      endcase
    end else if (sel < 85) begin
      for (int k = 0; k < 6; k++) f[k] = q_t'($urandom());
    end else begin
      for (int k = 0; k < 6; k++) f[k] = pick_extreme();
    end
    predict_ray(f[0], f[1], f[2], f[3], f[4], f[5]);
    send_ray(f[0], f[1], f[2], f[3], f[4], f[5]);
  endtask

  // ---------------- directed rays ----------------
  q_t   ray_tab[N_ROWS][6];
  int   tab_n[N_ROWS];         // typed beats, 0 means use the predictor
  hit_t tab_hits[N_ROWS][2];

  initial begin
    int sent;
    // all zero: nothing at all
    ray_tab[0] = '{0, 0, 0, 0, 0, 0};
    tab_n[0] = 1;
    tab_hits[0][0] = '{tval: 0, kind: KIND_NONE, last: 1'b1};
    // straight up the axis from below: grazes the apex, then base and cap
    ray_tab[1] = '{0, 0, -2 * ONE, 0, 0, ONE};
    tab_n[1] = 2;
    tab_hits[1][0] = '{tval: 3 * ONE, kind: KIND_CAP, last: 1'b0};
    tab_hits[1][1] = '{tval: 5 * (ONE / 2), kind: KIND_BASE, last: 1'b1};
    // flat ray missing the cone: negative discriminant
    ray_tab[2] = '{2 * ONE, 0, 0, 0, ONE, 0};
    tab_n[2] = 1;
    tab_hits[2][0] = '{tval: 0, kind: KIND_NONE, last: 1'b1};
    // flat ray through the side at z = 0.75
    ray_tab[3] = '{-2 * ONE, 0, 3 * (ONE / 4), ONE, 0, 0};
    // degenerate a: direction along the cone surface
    ray_tab[4] = '{ONE / 2, 0, 0, ONE, 0, ONE};
    // huge values, saturating paths
    ray_tab[5] = '{Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX};
    ray_tab[6] = '{Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN};
    ray_tab[7] = '{Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN};
    // dir z at and just above the threshold
    ray_tab[8] = '{ONE / 4, 0, 3 * (ONE / 4), ONE / 8, 0, 16};
    ray_tab[9] = '{ONE / 4, 0, 3 * (ONE / 4), ONE / 8, 0, 17};
    // coming down from above through cap and base
    ray_tab[10] = '{ONE / 8, -ONE / 8, 3 * ONE, 0, 0, -ONE};
    ray_tab[11] = '{Q_MIN, 0, ONE / 2, ONE, ONE / 4, -ONE / 2};
    for (int r = 3; r < N_ROWS; r++) tab_n[r] = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sent = 0;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      // registers change only with the pipeline empty
      wait_drained();
      case (ph)
        0: begin
          apb_check(ADDR_BASE_LEVEL, BASE_LEVEL_RST);
          apb_check(ADDR_NEAR_ZERO, NEAR_ZERO_RST);
        end
        1: set_regs('0, '0);
        2: set_regs(CFG_W'(1) << FB, CFG_W'(1) << FB);
        3: set_regs(CFG_W'($urandom_range(0, 1 << FB)), CFG_W'($urandom_range(0, 4096)));
        default: set_regs(CFG_W'($urandom_range(0, 1 << FB)),
                          CFG_W'($urandom_range(0, 1 << FB)));
      endcase
      if (ph == 0) begin
        for (int r = 0; r < N_ROWS; r++) begin
          if (tab_n[r] == 0)
            predict_ray(ray_tab[r][0], ray_tab[r][1], ray_tab[r][2],
                        ray_tab[r][3], ray_tab[r][4], ray_tab[r][5]);
          else
            for (int k = 0; k < tab_n[r]; k++) pending_hits.push_back(tab_hits[r][k]);
          send_ray(ray_tab[r][0], ray_tab[r][1], ray_tab[r][2],
                   ray_tab[r][3], ray_tab[r][4], ray_tab[r][5]);
        end
      end
      for (int k = 0; k < N_RAND; k++) begin
        // idle profile follows overall progress
        if (sent < 120) begin
          send_idle_pct = 7; recv_idle_pct = 46;
        end else if (sent < 240) begin
          send_idle_pct = 46; recv_idle_pct = 7;
        end else begin
          send_idle_pct = 0; recv_idle_pct = 0;
        end
        // hold the input once until the output has fully caught up
        if (ph == 2 && k == N_RAND / 2) begin
          in_valid <= 1'b0;
          while (pending_hits.size() != 0) @(posedge clk);
        end
        send_random_ray();
        sent++;
      end
    end

    wait_drained();
    if (errors == 0)
      $display("PASS ray_cone_intersection");
    else
      $display("FAIL ray_cone_intersection");
    $finish;
  end

  // run limit
  initial begin
    #3ms;
    $display("FAIL ray_cone_intersection");
    $finish;
  end

endmodule
